@@ hw/rtl/ffha_pkg.sv @@
`default_nettype none

package ffha_pkg;

  // Field widths of the request and response channels.
  localparam int ALLOC_W  = 12;
  localparam int OFF_W    = 12;
  localparam int STATUS_W = 2;
  localparam int TOTAL_W  = 13;

  // Request kinds.
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd2;

  // Per-field write strobes of a block header word.
  typedef struct packed {
    logic avail;
    logic size;
    logic prev;
    logic next;
  } hwe_t;

endpackage

`default_nettype wire

@@ hw/rtl/ffha_req_if.sv @@
`default_nettype none

interface ffha_req_if import ffha_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [ALLOC_W-1:0] alloc_bytes;
  logic [OFF_W-1:0]   free_offset;

  modport source(output valid, req_type, alloc_bytes, free_offset, input ready);
  modport sink(input valid, req_type, alloc_bytes, free_offset, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ffha_rsp_if.sv @@
`default_nettype none

interface ffha_rsp_if import ffha_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [OFF_W-1:0]    user_offset;
  logic [TOTAL_W-1:0]  avail_total;

  modport source(output valid, status, user_offset, avail_total, input ready);
  modport sink(input valid, status, user_offset, avail_total, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/ffha_mem.sv @@
`default_nettype none

module ffha_mem import ffha_pkg::*; #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int LW    = 13,
  parameter int SW    = 12
) (
  input  logic          clk,
  // Header read port.
  input  logic          hrd_en,
  input  logic [AW-1:0] hrd_addr,
  output logic          hrd_avail,
  output logic [SW-1:0] hrd_size,
  output logic [LW-1:0] hrd_prev,
  output logic [LW-1:0] hrd_next,
  // Header write port with per-field strobes.
  input  hwe_t          hwe,
  input  logic [AW-1:0] hwr_addr,
  input  logic          hwr_avail,
  input  logic [SW-1:0] hwr_size,
  input  logic [LW-1:0] hwr_prev,
  input  logic [LW-1:0] hwr_next,
  // Footer read and write ports.
  input  logic          frd_en,
  input  logic [AW-1:0] frd_addr,
  output logic [SW-1:0] frd_size,
  input  logic          fwr_en,
  input  logic [AW-1:0] fwr_addr,
  input  logic [SW-1:0] fwr_size
);

  typedef struct packed {
    logic          avail;
    logic [SW-1:0] size;
    logic [LW-1:0] prev;
    logic [LW-1:0] next;
  } hword_t;

  hword_t        hmem [DEPTH];
  logic [SW-1:0] fmem [DEPTH];
  hword_t        hrd_q;
  logic [SW-1:0] frd_q;

  // Header memory: field-masked write, registered read.
  always_ff @(posedge clk) begin
    if (hwe.avail) hmem[hwr_addr].avail <= hwr_avail;
    if (hwe.size) hmem[hwr_addr].size <= hwr_size;
    if (hwe.prev) hmem[hwr_addr].prev <= hwr_prev;
    if (hwe.next) hmem[hwr_addr].next <= hwr_next;
    if (hrd_en) hrd_q <= hmem[hrd_addr];
  end

  // Footer memory.
  always_ff @(posedge clk) begin
    if (fwr_en) fmem[fwr_addr] <= fwr_size;
    if (frd_en) frd_q <= fmem[frd_addr];
  end

  assign hrd_avail = hrd_q.avail;
  assign hrd_size  = hrd_q.size;
  assign hrd_prev  = hrd_q.prev;
  assign hrd_next  = hrd_q.next;
  assign frd_size  = frd_q;

endmodule

`default_nettype wire

@@ hw/rtl/first_fit_heap_allocator_top.sv @@
// First-fit heap allocator with boundary tags and an explicit available list.
// The request channel carries an allocation (req_type 0, alloc_bytes) or a
// free (req_type 1, free_offset); every request yields exactly one response
// with a status, the granted user offset and the bytes left on the list.
// All block state lives in a header memory and a footer memory, each with a
// registered read; a sequencer reads, modifies and writes back one access at
// a time, so requests are handled one after another.
// An allocation walks the available list first-fit, visiting at most
// HEAP_SIZE / OVERHEAD_BYTES + 1 blocks, and then either reports no fit or
// grants the whole block or splits it. A free is either ignored or taken;
// a taken free merges the block with its available neighbors. The walk over
// the list and the single header port set how long each request takes.
// After reset the block writes the initial heap block and then raises
// ready. A finished response sits in an output register, and the next
// request is taken while it waits; if the receiver still stalls when a
// second response is ready, the sequencer holds until the register empties.
`default_nettype none

module first_fit_heap_allocator_top import ffha_pkg::*; #(
  parameter int HEAP_SIZE      = 4096,
  parameter int HEAD_BYTES     = 32,
  parameter int FOOT_BYTES     = 8,
  parameter int OVERHEAD_BYTES = 40
) (
  input logic      clk,
  input logic      rst,
  ffha_req_if.sink req,
  ffha_rsp_if.source rsp
);

  localparam int AW = $clog2(HEAP_SIZE);
  localparam int LW = AW + 1;
  localparam int SW = AW;
  localparam int CW = ((LW > TOTAL_W) ? LW : TOTAL_W) + 2;
  localparam int WALK_MAX = HEAP_SIZE / OVERHEAD_BYTES + 1;
  localparam int STW = $clog2(WALK_MAX + 1);

  localparam logic [CW-1:0] NIL_C  = CW'(HEAP_SIZE);
  localparam logic [CW-1:0] HEAD_C = CW'(HEAD_BYTES);
  localparam logic [CW-1:0] FOOT_C = CW'(FOOT_BYTES);
  localparam logic [CW-1:0] OH_C   = CW'(OVERHEAD_BYTES);
  localparam logic [LW-1:0] NIL    = LW'(HEAP_SIZE);
  localparam logic [SW-1:0] SZ0    = SW'(HEAP_SIZE - OVERHEAD_BYTES);
  localparam logic [AW-1:0] FOOT0_ADDR = AW'(HEAP_SIZE - FOOT_BYTES);
  localparam logic [STW-1:0] WALK_LIM = STW'(WALK_MAX);

  typedef enum logic [17:0] {
    S_INIT   = 18'h00001,
    S_IDLE   = 18'h00002,
    S_WALK   = 18'h00004,
    S_WDAT   = 18'h00008,
    S_RM_RD  = 18'h00010,
    S_RM_A   = 18'h00020,
    S_RM_B   = 18'h00040,
    S_ASPLIT = 18'h00080,
    S_ASPL2  = 18'h00100,
    S_AF_A   = 18'h00200,
    S_AF_B   = 18'h00400,
    S_FCHK   = 18'h00800,
    S_MU_RD  = 18'h01000,
    S_MU_LO  = 18'h02000,
    S_MU_HI  = 18'h04000,
    S_BELOW  = 18'h08000,
    S_BEL_D  = 18'h10000,
    S_DONE   = 18'h20000
  } state_t;

  // Where a shared list routine returns to.
  typedef enum logic [2:0] {
    R_ALLOC,
    R_RM_LO,
    R_RM_HI,
    R_FREE,
    R_MU_END,
    R_SPLIT
  } ret_t;

  state_t state;
  ret_t   ret;
  logic   second;

  logic [ALLOC_W-1:0] want;
  logic [LW-1:0]  base, cur, found, x, rp, rn, old_ff, lo, hi, ff, fb;
  logic [STW-1:0] steps;
  logic [SW-1:0]  old, asize, szlo, total;
  logic [STATUS_W-1:0] status_r;
  logic [OFF_W-1:0]    user_r;

  logic                out_valid;
  logic                out_load;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0]    out_user;
  logic [TOTAL_W-1:0]  out_total;

  // Memory port signals.
  logic          hrd_en, hrd_avail;
  logic [AW-1:0] hrd_addr, hwr_addr;
  logic [SW-1:0] hrd_size, hwr_size;
  logic [LW-1:0] hrd_prev, hrd_next, hwr_prev, hwr_next;
  hwe_t          hwe;
  logic          hwr_avail;
  logic          frd_en, fwr_en;
  logic [AW-1:0] frd_addr, fwr_addr;
  logic [SW-1:0] frd_size, fwr_size;

  ffha_mem #(
    .DEPTH(HEAP_SIZE),
    .AW(AW),
    .LW(LW),
    .SW(SW)
  ) u_mem (
    .clk(clk),
    .hrd_en(hrd_en),
    .hrd_addr(hrd_addr),
    .hrd_avail(hrd_avail),
    .hrd_size(hrd_size),
    .hrd_prev(hrd_prev),
    .hrd_next(hrd_next),
    .hwe(hwe),
    .hwr_addr(hwr_addr),
    .hwr_avail(hwr_avail),
    .hwr_size(hwr_size),
    .hwr_prev(hwr_prev),
    .hwr_next(hwr_next),
    .frd_en(frd_en),
    .frd_addr(frd_addr),
    .frd_size(frd_size),
    .fwr_en(fwr_en),
    .fwr_addr(fwr_addr),
    .fwr_size(fwr_size)
  );

  // Datapath arithmetic, computed at the common width CW and truncated where needed.
  logic [CW-1:0] off_c, b_c, size_c, want_c, old_c, fsz_c;
  logic [CW-1:0] end_c, up_c, fa_old_c, fa_want_c, hi_c, total_c, fhi_c;
  logic [CW-1:0] lo_b_c, cost_c, fb_c;
  logic          in_take, free_bad_in, split_ok, walk_go;
  logic [SW-1:0] rest;
  logic [LW-1:0] fb_sub, fb_add;
  state_t        mu_ret;

  assign off_c       = CW'(req.free_offset);
  assign b_c         = off_c - HEAD_C;
  assign free_bad_in = (off_c < HEAD_C) || (b_c >= NIL_C);
  assign size_c      = CW'(hrd_size);
  assign want_c      = CW'(want);
  assign old_c       = CW'(old);
  assign fsz_c       = CW'(frd_size);
  assign end_c       = CW'(base) + size_c + OH_C;
  assign split_ok    = old_c >= want_c + OH_C;
  assign rest        = SW'(old_c - want_c - OH_C);
  assign up_c        = CW'(found) + want_c + OH_C;
  assign fa_old_c    = CW'(found) + HEAD_C + old_c;
  assign fa_want_c   = CW'(found) + HEAD_C + want_c;
  assign hi_c        = CW'(lo) + size_c + OH_C;
  assign total_c     = CW'(szlo) + size_c + OH_C;
  assign fhi_c       = CW'(hi) + HEAD_C + size_c;
  assign lo_b_c      = CW'(base) - FOOT_C - HEAD_C - fsz_c;
  assign cost_c      = size_c + OH_C;
  assign fb_c        = CW'(fb);
  assign fb_sub      = (fb_c > cost_c) ? LW'(fb_c - cost_c) : '0;
  assign fb_add      = LW'(fb_c + CW'(asize) + OH_C);
  assign walk_go     = (cur < NIL) && (steps < WALK_LIM);
  assign mu_ret      = second ? S_DONE : S_BELOW;

  assign req.ready = (state == S_IDLE);
  assign in_take   = req.valid && req.ready;

  // The output register loads when it is empty or being emptied.
  assign out_load  = (state == S_DONE) && (!out_valid || rsp.ready);

  // Memory accesses issued by each sequencer step.
  always_comb begin
    hrd_en    = 1'b0;
    hrd_addr  = '0;
    hwe       = '0;
    hwr_addr  = '0;
    hwr_avail = 1'b0;
    hwr_size  = '0;
    hwr_prev  = '0;
    hwr_next  = '0;
    frd_en    = 1'b0;
    frd_addr  = '0;
    fwr_en    = 1'b0;
    fwr_addr  = '0;
    fwr_size  = '0;
    case (state)
      S_INIT: begin
        hwe       = '1;
        hwr_avail = 1'b1;
        hwr_size  = SZ0;
        hwr_prev  = NIL;
        hwr_next  = NIL;
        fwr_en    = 1'b1;
        fwr_addr  = FOOT0_ADDR;
        fwr_size  = SZ0;
      end
      S_IDLE: begin
        if (in_take && req.req_type == REQ_FREE && !free_bad_in) begin
          hrd_en   = 1'b1;
          hrd_addr = AW'(b_c);
        end
      end
      S_WALK: begin
        hrd_en   = walk_go;
        hrd_addr = AW'(cur);
      end
      S_RM_RD: begin
        hrd_en   = 1'b1;
        hrd_addr = AW'(x);
      end
      S_RM_A: begin
        if (hrd_prev < NIL) begin
          hwe.next = 1'b1;
          hwr_addr = AW'(hrd_prev);
          hwr_next = hrd_next;
        end
      end
      S_RM_B: begin
        if (rn < NIL) begin
          hwe.prev = 1'b1;
          hwr_addr = AW'(rn);
          hwr_prev = rp;
        end
      end
      S_ASPLIT: begin
        hwe.avail = 1'b1;
        hwr_addr  = AW'(found);
        if (split_ok) begin
          hwe.size = 1'b1;
          hwr_size = SW'(want);
          fwr_en   = fa_old_c < NIL_C;
          fwr_addr = AW'(fa_old_c);
          fwr_size = rest;
        end
      end
      S_ASPL2: begin
        fwr_en   = fa_want_c < NIL_C;
        fwr_addr = AW'(fa_want_c);
        fwr_size = SW'(want);
      end
      S_AF_A: begin
        hwe       = '1;
        hwr_addr  = AW'(x);
        hwr_avail = 1'b1;
        hwr_size  = asize;
        hwr_prev  = NIL;
        hwr_next  = ff;
      end
      S_AF_B: begin
        if (old_ff < NIL) begin
          hwe.prev = 1'b1;
          hwr_addr = AW'(old_ff);
          hwr_prev = x;
        end
      end
      S_MU_RD: begin
        hrd_en   = 1'b1;
        hrd_addr = AW'(lo);
      end
      S_MU_LO: begin
        hrd_en   = hrd_avail && (hi_c < NIL_C);
        hrd_addr = AW'(hi_c);
      end
      S_MU_HI: begin
        fwr_en   = hrd_avail && (fhi_c < NIL_C);
        fwr_addr = AW'(fhi_c);
        fwr_size = SW'(total_c);
      end
      S_BELOW: begin
        frd_en   = (base != '0) && (CW'(base) >= FOOT_C);
        frd_addr = AW'(CW'(base) - FOOT_C);
      end
      default: begin
      end
    endcase
  end

  // Sequencer and list registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      ff        <= '0;
      fb        <= LW'(HEAP_SIZE);
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_load || (out_valid && !rsp.ready);
      case (state)
        S_INIT: state <= S_IDLE;
        S_IDLE: begin
          if (in_take) begin
            user_r   <= '0;
            want     <= req.alloc_bytes;
            cur      <= ff;
            steps    <= '0;
            base     <= LW'(b_c);
            if (req.req_type == REQ_ALLOC) begin
              status_r <= ST_DONE;
              state    <= S_WALK;
            end else if (free_bad_in) begin
              status_r <= ST_IGNORED;
              state    <= S_DONE;
            end else begin
              status_r <= ST_DONE;
              state    <= S_FCHK;
            end
          end
        end
        S_WALK: begin
          if (walk_go) begin
            state <= S_WDAT;
          end else begin
            status_r <= ST_NOFIT;
            state    <= S_DONE;
          end
        end
        S_WDAT: begin
          if (size_c >= want_c) begin
            found <= cur;
            old   <= hrd_size;
            ret   <= R_ALLOC;
            state <= S_RM_A;
          end else begin
            cur   <= hrd_next;
            steps <= steps + STW'(1);
            state <= S_WALK;
          end
        end
        S_RM_RD: state <= S_RM_A;
        S_RM_A: begin
          rp <= hrd_prev;
          rn <= hrd_next;
          if (hrd_prev >= NIL) ff <= hrd_next;
          fb    <= fb_sub;
          state <= S_RM_B;
        end
        S_RM_B: begin
          case (ret)
            R_ALLOC: state <= S_ASPLIT;
            R_RM_LO: begin
              x     <= hi;
              ret   <= R_RM_HI;
              state <= S_RM_RD;
            end
            R_RM_HI: begin
              x     <= lo;
              asize <= total;
              ret   <= R_MU_END;
              state <= S_AF_A;
            end
            default: state <= S_DONE;
          endcase
        end
        S_ASPLIT: begin
          user_r <= OFF_W'(CW'(found) + HEAD_C);
          state  <= split_ok ? S_ASPL2 : S_DONE;
        end
        S_ASPL2: begin
          if (up_c < NIL_C) begin
            x     <= LW'(up_c);
            asize <= rest;
            ret   <= R_SPLIT;
            state <= S_AF_A;
          end else begin
            state <= S_DONE;
          end
        end
        S_AF_A: begin
          old_ff <= ff;
          ff     <= x;
          fb     <= fb_add;
          state  <= S_AF_B;
        end
        S_AF_B: begin
          case (ret)
            R_FREE: begin
              lo     <= base;
              second <= 1'b0;
              state  <= S_MU_RD;
            end
            R_MU_END: state <= mu_ret;
            default: state <= S_DONE;
          endcase
        end
        S_FCHK: begin
          if (end_c > NIL_C || hrd_avail) begin
            status_r <= ST_IGNORED;
            state    <= S_DONE;
          end else begin
            x     <= base;
            asize <= hrd_size;
            ret   <= R_FREE;
            state <= S_AF_A;
          end
        end
        S_MU_RD: state <= S_MU_LO;
        S_MU_LO: begin
          szlo <= hrd_size;
          hi   <= LW'(hi_c);
          if (!hrd_avail || hi_c >= NIL_C) begin
            state <= mu_ret;
          end else begin
            state <= S_MU_HI;
          end
        end
        S_MU_HI: begin
          if (!hrd_avail) begin
            state <= mu_ret;
          end else begin
            total <= SW'(total_c);
            x     <= lo;
            ret   <= R_RM_LO;
            state <= S_RM_RD;
          end
        end
        S_BELOW: begin
          if (base == '0 || CW'(base) < FOOT_C) begin
            state <= S_DONE;
          end else begin
            state <= S_BEL_D;
          end
        end
        S_BEL_D: begin
          if (CW'(base) < FOOT_C + HEAD_C + fsz_c) begin
            state <= S_DONE;
          end else begin
            lo     <= LW'(lo_b_c);
            second <= 1'b1;
            state  <= S_MU_RD;
          end
        end
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_INIT;
      endcase
    end
  end

  // Response payload register.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status <= status_r;
      out_user   <= user_r;
      out_total  <= TOTAL_W'(fb);
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.status      = out_status;
  assign rsp.user_offset = out_user;
  assign rsp.avail_total = out_total;

  // A failed or ignored request never reports a granted offset.
  a_user_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.status != ST_DONE) |-> rsp.user_offset == '0)
    else $error("user offset set on a non-granted response");

  // The available byte count never exceeds the heap.
  a_fb_range: assert property (@(posedge clk) disable iff (rst)
    state != S_INIT |-> fb <= LW'(HEAP_SIZE))
    else $error("available byte count beyond heap size");

  // The list walk is bounded.
  a_walk_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK || state == S_WDAT) |-> steps <= WALK_LIM)
    else $error("list walk exceeded its bound");

  // No memory write happens while waiting for a request.
  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_IDLE |-> (hwe == '0 && !fwr_en))
    else $error("memory write while idle");

  // After a request is taken the sequencer has left the idle step.
  a_take_busy: assert property (@(posedge clk) disable iff (rst)
    in_take |=> state != S_IDLE)
    else $error("request taken but sequencer stayed idle");

endmodule

`default_nettype wire
